[hdl/stu_pkg.sv]
// Shared types and constants of the multi-channel soft timer unit.
package stu_pkg;

    localparam int OPCODE_W    = 3;
    localparam int CHANNEL_W   = 3;
    localparam int PERIOD_W    = 20;
    localparam int TICK_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes as they arrive on the opcode port.
    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_RESTART = 3'd3,
        OP_SETPER  = 3'd4
    } op_t;

    // One command that survived classification, as it travels through the queue.
    typedef struct packed {
        op_t                  op;
        logic [CHANNEL_W-1:0] ch;
        logic                 rep;
        logic [PERIOD_W-1:0]  period;
    } cmd_t;

endpackage

[hdl/stu_front.sv]
// Front end: accepts input beats, drops ignored commands and registers the rest.
module stu_front
    import stu_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OPCODE_W-1:0]  opcode,
    input  logic [CHANNEL_W-1:0] channel,
    input  logic                 repeat_mode,
    input  logic [PERIOD_W-1:0]  period_value,
    output logic                 cmd_valid,
    output cmd_t                 cmd,
    input  logic                 cmd_ready
);

    logic stg_valid_reg;
    cmd_t stg_cmd_reg;
    logic ch_in_range;
    logic keep;
    logic accept;

    assign ch_in_range = (32'(channel) < 32'(CHANNELS));

    // Ticks always go through; channel operations only for a real channel.
    always_comb
    begin
        unique case (opcode)
            OP_TICK:                                   keep = 1'b1;
            OP_START, OP_STOP, OP_RESTART, OP_SETPER:  keep = ch_in_range;
            default:                                   keep = 1'b0;
        endcase
    end

    assign in_ready  = !stg_valid_reg || cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = stg_valid_reg;
    assign cmd       = stg_cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stg_valid_reg <= keep;
        end
        else if (cmd_ready)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            stg_cmd_reg.op     <= op_t'(opcode);
            stg_cmd_reg.ch     <= channel;
            stg_cmd_reg.rep    <= repeat_mode;
            stg_cmd_reg.period <= period_value;
        end
    end

endmodule

[hdl/stu_cmd_fifo.sv]
// Short command queue between the front end and the timer engine.
module stu_cmd_fifo
    import stu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[hdl/stu_engine.sv]
// Timer engine: carries out commands and scans the channels on every tick.
module stu_engine
    import stu_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int TICKS_PER_MS = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHANNEL_W-1:0] expired_channel,
    output logic                 last_event
);

    localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W   = $clog2(CHANNELS + 1);
    localparam int TPM_W   = $clog2(TICKS_PER_MS + 1);
    localparam int LIMIT_W = PERIOD_W + TPM_W;
    localparam int CMP_W   = (LIMIT_W > TICK_W) ? LIMIT_W : TICK_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t                 state_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic [CHANNELS-1:0]    active_reg;
    logic [CHANNELS-1:0]    repeat_reg;
    logic [CHANNELS-1:0]    lim_ok_reg;
    logic [CNT_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       ev_idx_reg;
    logic                   ev_valid_reg;
    logic [IDX_W-1:0]       pend_ch_reg;
    logic                   pend_valid_reg;
    logic                   out_valid_reg;
    logic [CHANNEL_W-1:0]   out_ch_reg;
    logic                   out_last_reg;

    logic [TICK_W-1:0]      start_mem [CHANNELS];
    logic [LIMIT_W-1:0]     lim_mem   [CHANNELS];
    logic [TICK_W-1:0]      st_rd_reg;
    logic [LIMIT_W-1:0]     lim_rd_reg;

    logic                   pop;
    logic [IDX_W-1:0]       cmd_idx;
    logic                   slot_free;
    logic [TICK_W-1:0]      elapsed;
    logic [LIMIT_W-1:0]     limit;
    logic                   expire;
    logic                   stall;
    logic                   advance;
    logic                   rd_more;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_en;
    logic                   st_we;
    logic [IDX_W-1:0]       st_waddr;
    logic                   lim_we;
    logic [LIMIT_W-1:0]     lim_next;
    logic                   push_mid;
    logic                   push_last;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_idx   = IDX_W'(cmd.ch);
    assign slot_free = !out_valid_reg || out_ready;

    // A channel whose period was never set has a zero limit.
    assign elapsed = tick_reg - st_rd_reg;
    assign limit   = lim_ok_reg[ev_idx_reg] ? lim_rd_reg : '0;
    assign expire  = ev_valid_reg && active_reg[ev_idx_reg]
                     && (CMP_W'(elapsed) >= CMP_W'(limit));

    // An expiry with an event already held needs the output register free.
    assign stall   = expire && pend_valid_reg && !slot_free;
    assign advance = (state_reg == ST_SCAN) && !stall;
    assign rd_more = (rd_idx_reg != CNT_W'(CHANNELS));
    assign rd_addr = rd_idx_reg[IDX_W-1:0];
    assign rd_en   = advance && rd_more;

    assign push_mid  = advance && expire && pend_valid_reg;
    assign push_last = (state_reg == ST_FLUSH) && pend_valid_reg && slot_free;

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = ev_idx_reg;
        if (pop && (cmd.op == OP_START || cmd.op == OP_RESTART))
        begin
            st_we    = 1'b1;
            st_waddr = cmd_idx;
        end
        else if (advance && expire && repeat_reg[ev_idx_reg])
        begin
            st_we    = 1'b1;
        end
    end

    assign lim_we   = pop && (cmd.op == OP_SETPER);
    assign lim_next = LIMIT_W'(cmd.period) * LIMIT_W'(TICKS_PER_MS);

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            start_mem[st_waddr] <= tick_reg;
        end
        if (rd_en)
        begin
            st_rd_reg <= start_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lim_we)
        begin
            lim_mem[cmd_idx] <= lim_next;
        end
        if (rd_en)
        begin
            lim_rd_reg <= lim_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            active_reg     <= '0;
            repeat_reg     <= '0;
            lim_ok_reg     <= '0;
            rd_idx_reg     <= '0;
            ev_idx_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            pend_ch_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_ch_reg     <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        unique case (cmd.op)
                            OP_TICK:
                            begin
                                tick_reg       <= tick_reg + 1'b1;
                                rd_idx_reg     <= '0;
                                ev_valid_reg   <= 1'b0;
                                pend_valid_reg <= 1'b0;
                                state_reg      <= ST_SCAN;
                            end
                            OP_START:
                            begin
                                active_reg[cmd_idx] <= 1'b1;
                                repeat_reg[cmd_idx] <= cmd.rep;
                            end
                            OP_STOP:
                            begin
                                active_reg[cmd_idx] <= 1'b0;
                            end
                            OP_SETPER:
                            begin
                                lim_ok_reg[cmd_idx] <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (!stall)
                    begin
                        ev_valid_reg <= rd_more;
                        if (rd_more)
                        begin
                            ev_idx_reg <= rd_addr;
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                        end
                        if (expire)
                        begin
                            if (!repeat_reg[ev_idx_reg])
                            begin
                                active_reg[ev_idx_reg] <= 1'b0;
                            end
                            pend_ch_reg    <= ev_idx_reg;
                            pend_valid_reg <= 1'b1;
                        end
                        if (!rd_more && !ev_valid_reg)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (!pend_valid_reg || slot_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (push_mid || push_last)
            begin
                out_valid_reg <= 1'b1;
                out_ch_reg    <= CHANNEL_W'(pend_ch_reg);
                out_last_reg  <= push_last;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign expired_channel = out_ch_reg;
    assign last_event      = out_last_reg;

endmodule

[hdl/multi_channel_soft_timer_unit.sv]
// Top level of the multi-channel soft timer unit.
//
//  channel | signals                                        | direction | one beat
//  --------+------------------------------------------------+-----------+-------------------
//  in      | in_valid, in_ready, opcode, channel,           | to unit   | one timer command
//          | repeat_mode, period_value                      |           |
//  out     | out_valid, out_ready, expired_channel,         | from unit | one expiry event
//          | last_event                                     |           |
//
// Start, stop, restart and set-period commands finish in the cycle the engine takes them
// from the queue, so they flow at one per cycle. A tick holds the engine from the cycle
// it is taken, through the scan (one channel's start tick and limit are read from the
// memories per cycle unless the scan stops, and checked in the cycle after) and until
// the final event is handed over.
// There is no clearing pass after reset; the unit takes beats right away.
// The scan stops when an expiry is found while one event is held back and the output
// register is still full, and the final hand-over waits for the output register; the
// front end keeps taking beats until the queue and its own stage fill.
module multi_channel_soft_timer_unit
    import stu_pkg::*;
#(
    parameter int CHANNELS     = 8,
    parameter int TICKS_PER_MS = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OPCODE_W-1:0]  opcode,
    input  logic [CHANNEL_W-1:0] channel,
    input  logic                 repeat_mode,
    input  logic [PERIOD_W-1:0]  period_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CHANNEL_W-1:0] expired_channel,
    output logic                 last_event
);

    // Front end to queue.
    logic q_in_valid;
    logic q_in_ready;
    cmd_t q_in;

    // Queue to engine.
    logic q_out_valid;
    logic q_out_ready;
    cmd_t q_out;

    // The front end drops unknown opcodes and commands for channels that do not exist,
    // so only meaningful work reaches the queue.
    stu_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .channel      (channel),
        .repeat_mode  (repeat_mode),
        .period_value (period_value),
        .cmd_valid    (q_in_valid),
        .cmd          (q_in),
        .cmd_ready    (q_in_ready)
    );

    stu_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_cmd   (q_in),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_cmd   (q_out)
    );

    // The engine holds the tick counter and per-channel state. During a tick scan it keeps
    // the most recent expiry back by one, so the final event of the tick can be marked.
    stu_engine #(
        .CHANNELS     (CHANNELS),
        .TICKS_PER_MS (TICKS_PER_MS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (q_out_valid),
        .cmd_ready       (q_out_ready),
        .cmd             (q_out),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .expired_channel (expired_channel),
        .last_event      (last_event)
    );

    // The front end only refuses a beat while it holds a command of its own.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_in_valid)
        else $error("front end stalls with an empty stage");

    // Every channel operation handed to the engine addresses an existing channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_out_valid |-> (q_out.op == OP_TICK || 32'(q_out.ch) < 32'(CHANNELS)))
        else $error("out-of-range channel command reached the engine");

    // Reported channels always exist.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(expired_channel) < 32'(CHANNELS)))
        else $error("expiry event for a nonexistent channel");

endmodule
